>>> rtl/rrpr_pkg.sv
package rrpr_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   localparam logic [CSR_INDEX_W-1:0] CSR_CLIENT_IP     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIENT_MAC    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BALANCER_IP   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BALANCER_MAC  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKEND_COUNT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTINGS      = 3'd5;

   // settings_present bits
   localparam int SET_COUNT    = 0;
   localparam int SET_CLIENT   = 1;
   localparam int SET_BALANCER = 2;

   // header checks
   localparam logic [13:0] MIN_LEN_ETH = 14'd14;
   localparam logic [13:0] MIN_LEN_IP  = 14'd34;
   localparam logic [13:0] MIN_LEN_TCP = 14'd54;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;

   // table slot field width on the request word
   localparam int TBL_SLOT_W = 7;
   // table rows beyond this can never be written by a request
   localparam int TBL_MAX_ROWS = 128;

   // sum of the five header halfwords that do not change
   localparam int PSUM_W = 19;
   // full checksum sum before folding
   localparam int CSUM_W = 20;

   typedef enum logic [1:0] {
      VERDICT_ABORT = 2'd0,
      VERDICT_PASS  = 2'd1,
      VERDICT_SEND  = 2'd2,
      VERDICT_TABLE = 2'd3
   } verdict_type;

   typedef enum logic [2:0] {
      KIND_ABORT,
      KIND_PASS,
      KIND_TO_BACKEND,
      KIND_TO_CLIENT,
      KIND_TABLE_WRITE
   } kind_type;

   typedef struct packed {
      logic [31:0] client_ip;
      logic [47:0] client_mac;
      logic [31:0] balancer_ip;
      logic [47:0] balancer_mac;
      logic [7:0]  backend_count;
      logic [2:0]  settings;
   } cfg_type;

   // classified word handed from front to back
   typedef struct packed {
      kind_type          kind;
      logic [PSUM_W-1:0] psum;
      logic [31:0]       tbl_ip;
      logic [47:0]       tbl_mac;
   } op_type;

endpackage

>>> rtl/rrpr_channels.sv
interface rrpr_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [13:0] frame_length;
   logic [15:0] ether_type;
   logic [31:0] ip_word_first;
   logic [31:0] ip_word_second;
   logic [15:0] ip_ttl_protocol;
   logic [31:0] ip_source;
   logic [6:0]  table_slot;
   logic [31:0] table_ip;
   logic [47:0] table_mac;

   modport source (
      output valid, req_type, frame_length, ether_type, ip_word_first, ip_word_second,
             ip_ttl_protocol, ip_source, table_slot, table_ip, table_mac,
      input  ready
   );

   modport sink (
      input  valid, req_type, frame_length, ether_type, ip_word_first, ip_word_second,
             ip_ttl_protocol, ip_source, table_slot, table_ip, table_mac,
      output ready
   );
endinterface

interface rrpr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  verdict;
   logic [47:0] new_dest_mac;
   logic [47:0] new_source_mac;
   logic [31:0] new_dest_ip;
   logic [31:0] new_source_ip;
   logic [15:0] new_checksum;
   logic [6:0]  chosen_slot;

   modport source (
      output valid, verdict, new_dest_mac, new_source_mac, new_dest_ip, new_source_ip,
             new_checksum, chosen_slot,
      input  ready
   );

   modport sink (
      input  valid, verdict, new_dest_mac, new_source_mac, new_dest_ip, new_source_ip,
             new_checksum, chosen_slot,
      output ready
   );
endinterface

>>> rtl/round_robin_packet_rewriter.sv
// Round-robin load balancer header rewrite. Each req_ word is either a packet
// header to judge or a write of one backend table row; each gives exactly one
// rsp_ word, in order. Client TCP/IPv4 packets go to the backend row at the
// round-robin pointer, other TCP/IPv4 packets go back to the client, with the
// balancer as new source and a fresh 20-byte header checksum. The block takes one
// word per cycle while rsp_ready is high; each word passes through the four-word
// queue between the classifier and the rewrite pipe, then the registered read of
// the single-port backend table, then the output register. The table reads as
// zero until a row is written; there is no clearing pass. Write csr_ registers
// only while no word is in flight.
module round_robin_packet_rewriter
   import rrpr_pkg::*;
#(
   parameter int BACKEND_SLOTS = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   rrpr_req_if.sink               req_ch,
   rrpr_rsp_if.source             rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PTR_W   = $clog2(BACKEND_SLOTS);
   localparam int SLOT_W  = (PTR_W > TBL_SLOT_W) ? PTR_W : TBL_SLOT_W;
   localparam int OP_W    = $bits(op_type);
   localparam int ENT_W   = OP_W + SLOT_W;
   localparam int Q_DEPTH = 4;

   cfg_type           cfg_ff;
   cfg_type           cfg_in;

   logic              push_valid;
   logic              push_ready;
   op_type            push_op;
   logic [SLOT_W-1:0] push_slot;
   logic              pop_valid;
   logic              pop_ready;
   logic [ENT_W-1:0]  pop_data;
   op_type            pop_op;
   logic [SLOT_W-1:0] pop_slot;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CLIENT_IP:     cfg_in.client_ip     = csr_wdata[31:0];
            CSR_CLIENT_MAC:    cfg_in.client_mac    = csr_wdata[47:0];
            CSR_BALANCER_IP:   cfg_in.balancer_ip   = csr_wdata[31:0];
            CSR_BALANCER_MAC:  cfg_in.balancer_mac  = csr_wdata[47:0];
            CSR_BACKEND_COUNT: cfg_in.backend_count = csr_wdata[7:0];
            CSR_SETTINGS:      cfg_in.settings      = csr_wdata[2:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rrpr_front #(
      .BACKEND_SLOTS (BACKEND_SLOTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .push_slot  (push_slot)
   );

   rrpr_fifo #(
      .WIDTH (ENT_W),
      .DEPTH (Q_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_op, push_slot}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign pop_op   = op_type'(pop_data[ENT_W-1:SLOT_W]);
   assign pop_slot = pop_data[SLOT_W-1:0];

   rrpr_back #(
      .BACKEND_SLOTS (BACKEND_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_op    (pop_op),
      .pop_slot  (pop_slot),
      .rsp       (rsp_ch)
   );

endmodule

>>> rtl/rrpr_front.sv
module rrpr_front
   import rrpr_pkg::*;
#(
   parameter int BACKEND_SLOTS = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   rrpr_req_if.sink          req,
   output logic              push_valid,
   input  logic              push_ready,
   output op_type            push_op,
   output logic [(($clog2(BACKEND_SLOTS) > TBL_SLOT_W) ? $clog2(BACKEND_SLOTS)
                                                        : TBL_SLOT_W)-1:0] push_slot
);

   localparam int PTR_W  = $clog2(BACKEND_SLOTS);
   localparam int SLOT_W = (PTR_W > TBL_SLOT_W) ? PTR_W : TBL_SLOT_W;
   localparam int CNT_W  = ($clog2(BACKEND_SLOTS + 1) > 8) ? $clog2(BACKEND_SLOTS + 1) : 8;

   logic [PTR_W-1:0] rr_ptr_ff;
   logic [PTR_W-1:0] rr_ptr_in;
   logic [CNT_W-1:0] cnt_raw;
   logic [CNT_W-1:0] cnt_eff;
   logic [CNT_W-1:0] ptr_ext;
   logic [CNT_W-1:0] ptr_inc;
   logic [PTR_W-1:0] ptr_next;
   logic             ptr_ok;
   logic             advance;
   logic             accept;
   kind_type         kind;

   assign cnt_raw = CNT_W'(cfg.backend_count);
   assign cnt_eff = (cnt_raw > CNT_W'(BACKEND_SLOTS)) ? CNT_W'(BACKEND_SLOTS) : cnt_raw;
   assign ptr_ext = CNT_W'(rr_ptr_ff);
   assign ptr_ok  = ptr_ext < cnt_eff;
   assign ptr_inc = ptr_ext + CNT_W'(1);
   assign ptr_next = (ptr_inc == cnt_eff) ? '0 : ptr_inc[PTR_W-1:0];

   always_comb begin
      kind    = KIND_ABORT;
      advance = 1'b0;
      priority if (req.req_type) begin
         kind = KIND_TABLE_WRITE;
      end else if (req.frame_length < MIN_LEN_ETH) begin
         kind = KIND_ABORT;
      end else if (req.ether_type != ETHERTYPE_IPV4) begin
         kind = KIND_PASS;
      end else if (req.frame_length < MIN_LEN_IP) begin
         kind = KIND_ABORT;
      end else if (req.ip_ttl_protocol[7:0] != PROTO_TCP) begin
         kind = KIND_PASS;
      end else if (req.frame_length < MIN_LEN_TCP) begin
         kind = KIND_ABORT;
      end else if (!cfg.settings[SET_COUNT] || !cfg.settings[SET_CLIENT]) begin
         kind = KIND_ABORT;
      end else if (req.ip_source == cfg.client_ip) begin
         if (ptr_ok) begin
            // pointer moves even if the balancer setting then aborts the word
            advance = 1'b1;
            kind    = cfg.settings[SET_BALANCER] ? KIND_TO_BACKEND : KIND_ABORT;
         end else begin
            kind = KIND_ABORT;
         end
      end else begin
         kind = cfg.settings[SET_BALANCER] ? KIND_TO_CLIENT : KIND_ABORT;
      end
   end

   assign accept     = req.valid && push_ready;
   assign req.ready  = push_ready;
   assign push_valid = req.valid;

   assign push_op.kind    = kind;
   assign push_op.psum    = PSUM_W'(req.ip_word_first[31:16]) + PSUM_W'(req.ip_word_first[15:0])
                          + PSUM_W'(req.ip_word_second[31:16])
                          + PSUM_W'(req.ip_word_second[15:0])
                          + PSUM_W'(req.ip_ttl_protocol);
   assign push_op.tbl_ip  = req.table_ip;
   assign push_op.tbl_mac = req.table_mac;
   assign push_slot = req.req_type ? SLOT_W'(req.table_slot) : SLOT_W'(rr_ptr_ff);

   assign rr_ptr_in = (accept && advance) ? ptr_next : rr_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rr_ptr_ff <= '0;
      end else begin
         rr_ptr_ff <= rr_ptr_in;
      end
   end

   a_ptr_below_count: assert property (@(posedge clock) disable iff (reset)
      accept && advance |=> CNT_W'(rr_ptr_ff) < $past(cnt_eff))
      else $error("round-robin pointer left the backend range");

endmodule

>>> rtl/rrpr_fifo.sv
module rrpr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] q_mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff;
   logic [AW-1:0]    wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff;
   logic [AW-1:0]    rd_ptr_in;
   logic [CW-1:0]    cnt_ff;
   logic [CW-1:0]    cnt_in;
   logic             push;
   logic             pop;

   assign push_ready = cnt_ff < CW'(DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = q_mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      cnt_in = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_fill_tracks: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + CW'(1))
      else $error("queue fill count lost a word");

endmodule

>>> rtl/rrpr_back.sv
module rrpr_back
   import rrpr_pkg::*;
#(
   parameter int BACKEND_SLOTS = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         pop_valid,
   output logic         pop_ready,
   input  op_type       pop_op,
   input  logic [(($clog2(BACKEND_SLOTS) > TBL_SLOT_W) ? $clog2(BACKEND_SLOTS)
                                                       : TBL_SLOT_W)-1:0] pop_slot,
   rrpr_rsp_if.source   rsp
);

   localparam int PTR_W     = $clog2(BACKEND_SLOTS);
   localparam int SLOT_W    = (PTR_W > TBL_SLOT_W) ? PTR_W : TBL_SLOT_W;
   localparam int TBL_DEPTH = (BACKEND_SLOTS < TBL_MAX_ROWS) ? BACKEND_SLOTS : TBL_MAX_ROWS;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);
   localparam int ENT_W     = 80;

   function automatic logic [15:0] fold_sum(input logic [CSUM_W-1:0] s);
      logic [CSUM_W-1:0] acc;
      acc = s;
      for (int i = 0; i < 4; i++) begin
         acc = CSUM_W'(acc[15:0]) + CSUM_W'(acc[CSUM_W-1:16]);
      end
      return ~acc[15:0];
   endfunction

   // backend table: {ip, mac}, rows read as zero until written
   logic [ENT_W-1:0]     tbl_mem_ff [TBL_DEPTH];
   logic [TBL_DEPTH-1:0] tbl_vld_ff;
   logic [ENT_W-1:0]     rd_ent_ff;
   logic                 rd_hit_ff;

   logic                 take;
   logic                 in_range;
   logic [TBL_AW-1:0]    idx;
   logic                 tbl_wr;

   logic                 b_vld_ff;
   kind_type             b_kind_ff;
   logic [SLOT_W-1:0]    b_slot_ff;
   logic [PSUM_W-1:0]    b_psum_ff;

   logic                 out_load;
   logic                 rsp_vld_ff;
   logic                 rsp_vld_in;
   verdict_type          rsp_verdict_ff;
   verdict_type          rsp_verdict_in;
   logic [47:0]          rsp_dmac_ff;
   logic [47:0]          rsp_dmac_in;
   logic [47:0]          rsp_smac_ff;
   logic [47:0]          rsp_smac_in;
   logic [31:0]          rsp_dip_ff;
   logic [31:0]          rsp_dip_in;
   logic [31:0]          rsp_sip_ff;
   logic [31:0]          rsp_sip_in;
   logic [15:0]          rsp_csum_ff;
   logic [15:0]          rsp_csum_in;
   logic [6:0]           rsp_slot_ff;
   logic [6:0]           rsp_slot_in;

   logic [31:0]          dst_ip;
   logic [47:0]          dst_mac;
   logic [CSUM_W-1:0]    csum_raw;

   // stage A: pop, table access
   assign out_load  = !rsp_vld_ff || rsp.ready;
   assign pop_ready = !b_vld_ff || out_load;
   assign take      = pop_valid && pop_ready;
   assign in_range  = {1'b0, pop_slot} < (SLOT_W + 1)'(TBL_DEPTH);
   assign idx       = pop_slot[TBL_AW-1:0];
   assign tbl_wr    = take && (pop_op.kind == KIND_TABLE_WRITE) && in_range;

   always_ff @(posedge clock) begin
      if (tbl_wr) begin
         tbl_mem_ff[idx] <= {pop_op.tbl_ip, pop_op.tbl_mac};
      end
      if (take) begin
         rd_ent_ff <= tbl_mem_ff[idx];
         b_kind_ff <= pop_op.kind;
         b_slot_ff <= pop_slot;
         b_psum_ff <= pop_op.psum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_vld_ff <= '0;
         rd_hit_ff  <= 1'b0;
         b_vld_ff   <= 1'b0;
      end else begin
         if (tbl_wr) begin
            tbl_vld_ff[idx] <= 1'b1;
         end
         if (take) begin
            rd_hit_ff <= in_range && tbl_vld_ff[idx];
         end
         if (pop_ready) begin
            b_vld_ff <= take;
         end
      end
   end

   // stage B: build the result word
   always_comb begin
      dst_ip  = rd_hit_ff ? rd_ent_ff[79:48] : '0;
      dst_mac = rd_hit_ff ? rd_ent_ff[47:0] : '0;
      if (b_kind_ff == KIND_TO_CLIENT) begin
         dst_ip  = cfg.client_ip;
         dst_mac = cfg.client_mac;
      end
      csum_raw = CSUM_W'(b_psum_ff) + CSUM_W'(cfg.balancer_ip[31:16])
               + CSUM_W'(cfg.balancer_ip[15:0]) + CSUM_W'(dst_ip[31:16])
               + CSUM_W'(dst_ip[15:0]);

      rsp_verdict_in = VERDICT_ABORT;
      rsp_dmac_in    = '0;
      rsp_smac_in    = '0;
      rsp_dip_in     = '0;
      rsp_sip_in     = '0;
      rsp_csum_in    = '0;
      rsp_slot_in    = '0;
      unique case (b_kind_ff)
         KIND_ABORT:       rsp_verdict_in = VERDICT_ABORT;
         KIND_PASS:        rsp_verdict_in = VERDICT_PASS;
         KIND_TABLE_WRITE: rsp_verdict_in = VERDICT_TABLE;
         KIND_TO_BACKEND, KIND_TO_CLIENT: begin
            rsp_verdict_in = VERDICT_SEND;
            rsp_dmac_in    = dst_mac;
            rsp_smac_in    = cfg.balancer_mac;
            rsp_dip_in     = dst_ip;
            rsp_sip_in     = cfg.balancer_ip;
            rsp_csum_in    = fold_sum(csum_raw);
            rsp_slot_in    = (b_kind_ff == KIND_TO_BACKEND) ? b_slot_ff[6:0] : '0;
         end
         default:          rsp_verdict_in = VERDICT_ABORT;
      endcase

      rsp_vld_in = rsp_vld_ff;
      if (out_load) begin
         rsp_vld_in = b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && b_vld_ff) begin
         rsp_verdict_ff <= rsp_verdict_in;
         rsp_dmac_ff    <= rsp_dmac_in;
         rsp_smac_ff    <= rsp_smac_in;
         rsp_dip_ff     <= rsp_dip_in;
         rsp_sip_ff     <= rsp_sip_in;
         rsp_csum_ff    <= rsp_csum_in;
         rsp_slot_ff    <= rsp_slot_in;
      end
   end

   assign rsp.valid          = rsp_vld_ff;
   assign rsp.verdict        = rsp_verdict_ff;
   assign rsp.new_dest_mac   = rsp_dmac_ff;
   assign rsp.new_source_mac = rsp_smac_ff;
   assign rsp.new_dest_ip    = rsp_dip_ff;
   assign rsp.new_source_ip  = rsp_sip_ff;
   assign rsp.new_checksum   = rsp_csum_ff;
   assign rsp.chosen_slot    = rsp_slot_ff;

   a_quiet_unless_sent: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_verdict_ff != VERDICT_SEND |->
         rsp_dmac_ff == '0 && rsp_smac_ff == '0 && rsp_dip_ff == '0 && rsp_sip_ff == '0
         && rsp_csum_ff == '0 && rsp_slot_ff == '0)
      else $error("non-send result carries rewrite fields");

   a_row_marked: assert property (@(posedge clock) disable iff (reset)
      tbl_wr |=> tbl_vld_ff[$past(idx)])
      else $error("written table row not marked valid");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      b_vld_ff && !out_load |=> b_vld_ff && $stable(b_slot_ff) && $stable(b_kind_ff))
      else $error("stalled stage B word changed");

endmodule
